// ===== src/zvc_pkg.sv =====
// ----------------------------------------------------------------------------
// zvc_pkg: shared types and constants of the zigzag varint codec
// Byte layout of the base-128 code, command and result codes, and the
// result record that the encoder and decoder hand to the output stage.
// ----------------------------------------------------------------------------
package zvc_pkg;

    localparam int VALUE_W         = 64;
    localparam int BYTE_W          = 8;
    localparam int DIGIT_W         = 7;
    localparam int MAX_CODED_BYTES = 10;
    localparam int COUNT_W         = $clog2(MAX_CODED_BYTES);
    localparam int POS_W           = $clog2(DIGIT_W * MAX_CODED_BYTES);
    localparam int PLACE_W         = DIGIT_W * MAX_CODED_BYTES;

    // Continuation flag position within a coded byte
    localparam int CONT_BIT = BYTE_W - 1;

    // Largest legal final byte in the last byte position
    localparam logic [BYTE_W-1:0] LAST_POS_MAX = 8'd1;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic [BYTE_W-1:0]         coded;
        logic                      last;
        logic signed [VALUE_W-1:0] value;
        logic                      ovf;
    } t_result;

endpackage

// ===== src/zvc_encoder.sv =====
// ----------------------------------------------------------------------------
// zvc_encoder: digit-serial zigzag varint encoder
// Loads a zigzag-mapped value into a shift register and emits one seven-bit
// digit per taken byte, low digit first.
// ----------------------------------------------------------------------------
module zvc_encoder
    import zvc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_take,
    output logic                      o_busy,
    output t_result                   o_res
);

    logic [VALUE_W-1:0] r_shift, n_shift;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               last;

    // last digit once nothing remains above it, or at the byte limit
    assign last = (r_shift[VALUE_W-1:DIGIT_W] == '0)
               || (r_cnt == COUNT_W'(MAX_CODED_BYTES - 1));

    always_comb begin
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_load) begin
            // zigzag: shift left, invert all bits of a negative value
            n_shift = {i_value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{i_value[VALUE_W-1]}};
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy && i_take) begin
            n_shift = r_shift >> DIGIT_W;
            n_cnt   = r_cnt + COUNT_W'(1);
            n_busy  = !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
    end

    always_comb begin
        o_res        = '0;
        o_res.kind   = KIND_BYTE;
        o_res.coded  = {!last, r_shift[DIGIT_W-1:0]};
        o_res.last   = last;
    end

    assign o_busy = r_busy;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < COUNT_W'(MAX_CODED_BYTES)))
        else $error("encoder byte count beyond limit");

endmodule

// ===== src/zvc_decoder.sv =====
// ----------------------------------------------------------------------------
// zvc_decoder: byte-serial varint decoder
// Places each incoming seven-bit digit at its position in the accumulator
// and undoes the zigzag mapping on the final byte.
// ----------------------------------------------------------------------------
module zvc_decoder
    import zvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_strobe,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0]   pos;
    logic [PLACE_W-1:0] placed;
    logic [VALUE_W-1:0] gathered;
    logic               last_pos;
    logic               ovf;
    logic               cont;

    assign last_pos = (r_cnt >= COUNT_W'(MAX_CODED_BYTES - 1));
    assign ovf      = last_pos && (i_byte[CONT_BIT] || (i_byte > LAST_POS_MAX));
    assign cont     = i_byte[CONT_BIT] && !ovf;
    assign pos      = POS_W'(DIGIT_W * r_cnt);

    always_comb begin
        placed = '0;
        placed[pos +: DIGIT_W] = i_byte[DIGIT_W-1:0];
    end

    assign gathered = r_acc | placed[VALUE_W-1:0];

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_strobe) begin
            if (cont) begin
                n_acc = gathered;
                n_cnt = r_cnt + COUNT_W'(1);
            end else begin
                n_acc = '0;
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    assign o_res_valid = i_strobe && !cont;

    always_comb begin
        o_res      = '0;
        o_res.kind = KIND_VALUE;
        o_res.ovf  = ovf;
        if (!ovf) begin
            o_res.value = {1'b0, gathered[VALUE_W-1:1]} ^ {VALUE_W{gathered[0]}};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < COUNT_W'(MAX_CODED_BYTES))
        else $error("decoder byte count beyond limit");

endmodule

// ===== src/zigzag_varint_codec.sv =====
// ----------------------------------------------------------------------------
// zigzag_varint_codec: zigzag base-128 varint codec for signed 64-bit values
// Encodes a value into 1 to 10 coded bytes, or decodes coded bytes back into
// a value, one item at a time over a valid/ready stream.
// ----------------------------------------------------------------------------
// Usage and timing: an item with command 1 (decode) delivers one coded byte;
// it gives no result while bit 7 is set and one value result on the final
// byte, so a steady byte stream decodes at one item per cycle while the
// output register drains. An item with command 0 (encode) loads the
// zigzag-mapped value into the encoder shift register, which sends one
// seven-bit digit per cycle while the output register is free: the input
// is held off from the load until the last coded byte of the value has
// been sent (load, then its digits); a consumer stall prolongs this.
// The digit rate of that shift register sets the encode throughput. Results
// pass through a single output register; the next item is taken only while
// that register is empty or being drained, so a result that waits holds the
// input off. A tenth continuation byte, or a tenth byte above 1, gives a
// value of 0 with overflow set and restarts the decode; an encode in the
// middle of a decode leaves the partial decode intact.
// ----------------------------------------------------------------------------
module zigzag_varint_codec
    import zvc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_command,
    input  logic signed [VALUE_W-1:0] i_plain_value,
    input  logic [BYTE_W-1:0]         i_coded_byte,

    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_result_kind,
    output logic [BYTE_W-1:0]         o_out_byte,
    output logic                      o_last_byte,
    output logic signed [VALUE_W-1:0] o_decoded_value,
    output logic                      o_overflow
);

    logic    slot_free;
    logic    accept;
    logic    enc_load;
    logic    enc_busy;
    logic    enc_emit;
    logic    dec_strobe;
    logic    dec_valid;
    t_result enc_res;
    t_result dec_res;

    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;

    // output slot is free when empty or being drained this cycle
    assign slot_free  = !r_out_valid || i_ready;

    // hold off new items while the encoder still shifts digits out
    assign o_ready    = !enc_busy && slot_free;
    assign accept     = i_valid && o_ready;
    assign enc_load   = accept && (i_command == CMD_ENCODE);
    assign dec_strobe = accept && (i_command == CMD_DECODE);
    assign enc_emit   = enc_busy && slot_free;

    zvc_encoder u_encoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (enc_load),
        .i_value (i_plain_value),
        .i_take  (slot_free),
        .o_busy  (enc_busy),
        .o_res   (enc_res)
    );

    zvc_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_strobe    (dec_strobe),
        .i_byte      (i_coded_byte),
        .o_res_valid (dec_valid),
        .o_res       (dec_res)
    );

    // Output register: the encoder and the decoder never offer a result in
    // the same cycle, since a decode is only taken while the encoder idles.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (slot_free) begin
            n_out_valid = enc_emit || dec_valid;
            priority if (enc_emit) begin
                n_out = enc_res;
            end else if (dec_valid) begin
                n_out = dec_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_out.kind;
    assign o_out_byte      = r_out.coded;
    assign o_last_byte     = r_out.last;
    assign o_decoded_value = r_out.value;
    assign o_overflow      = r_out.ovf;

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enc_busy |-> !o_ready)
        else $error("item taken while encoder busy");

    a_cont_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_BYTE)) |->
            (o_out_byte[CONT_BIT] == !o_last_byte) && !o_overflow
            && (o_decoded_value == '0))
        else $error("encoded byte flags inconsistent");

    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_VALUE)) |->
            (o_out_byte == '0) && !o_last_byte
            && (!o_overflow || (o_decoded_value == '0)))
        else $error("decoded result fields inconsistent");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(enc_emit && dec_valid))
        else $error("encoder and decoder results collide");

endmodule

// ===== tb/tb_zigzag_varint_codec.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_zigzag_varint_codec: self-checking bench for the zigzag varint codec
// Streams encode and decode items at the block over valid/ready. Each item
// is run through an in-bench zigzag/base-128 model at the moment it is taken.
// Every result is checked field by field against the oldest result still
// owed. Both sides idle at random. The receiver also holds off for a long
// stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_zigzag_varint_codec;
    import zvc_pkg::*;

    localparam int TOTAL_ITEMS    = 370;
    localparam int CALM_FROM      = 160;  // start of the stretch with no idling
    localparam int HOLD_FROM      = 250;  // start of the long receiver hold-off
    localparam int HOLD_RUN_ITEMS = 40;
    localparam int RX_HOLD_CYCLES = 60;
    localparam int MAX_GAP        = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int STALL_LIMIT    = 1000;

    localparam logic [VALUE_W-1:0] MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] MIN_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef logic [BYTE_W-1:0] t_code_q [$];

    // ------------------------------------------------------------------------
    // Zigzag varint tracker: mirrors the codec state and owes one result per
    // coded byte, or one per completed (or overflowed) decode.
    // ------------------------------------------------------------------------
    class zz_varint_tracker;
        t_result              due_results [$];
        logic [VALUE_W-1:0]   gathered;
        logic [3:0]           gathered_count;
        int                   errors;

        function new();
            gathered       = '0;
            gathered_count = '0;
            errors         = 0;
        endfunction

        // Split a value into its zigzag base-128 bytes, low digit first
        function void code_value(input logic [VALUE_W-1:0] v, output t_code_q q);
            logic [VALUE_W-1:0] zz;
            int                 n;
            zz = {v[VALUE_W-2:0], 1'b0};
            if (v[VALUE_W-1]) zz = ~zz;
            q.delete();
            for (n = 0; n < MAX_CODED_BYTES - 1 && zz >= 64'h80; n++) begin
                q.push_back({1'b1, zz[DIGIT_W-1:0]});
                zz = zz >> DIGIT_W;
            end
            q.push_back({1'b0, zz[DIGIT_W-1:0]});
        endfunction

        function void owe_value(logic [VALUE_W-1:0] v, logic ovf);
            t_result r;
            r.kind  = KIND_VALUE;
            r.coded = '0;
            r.last  = 1'b0;
            r.value = v;
            r.ovf   = ovf;
            due_results.push_back(r);
        endfunction

        function void decode_byte(logic [BYTE_W-1:0] b);
            logic [VALUE_W-1:0] word;
            logic [VALUE_W-1:0] val;
            int                 shift;
            shift = (int'(gathered_count) * DIGIT_W) & 63;
            // The last byte position only takes a final byte of 0 or 1
            if (gathered_count >= MAX_CODED_BYTES - 1 &&
                (b[CONT_BIT] || b > LAST_POS_MAX)) begin
                gathered       = '0;
                gathered_count = '0;
                owe_value('0, 1'b1);
            end else if (b[CONT_BIT]) begin
                gathered       = gathered | (64'(b[DIGIT_W-1:0]) << shift);
                gathered_count = gathered_count + 4'd1;
            end else begin
                word = gathered | (64'(b) << shift);
                val  = word >> 1;
                if (word[0]) val = ~val;
                gathered       = '0;
                gathered_count = '0;
                owe_value(val, 1'b0);
            end
        endfunction

        // Note an item taken by the block; an encode leaves the decode as it is
        function void note_item(logic cmd, logic [VALUE_W-1:0] plain,
                                logic [BYTE_W-1:0] coded);
            t_code_q q;
            t_result r;
            if (cmd == CMD_ENCODE) begin
                code_value(plain, q);
                foreach (q[i]) begin
                    r.kind  = KIND_BYTE;
                    r.coded = q[i];
                    r.last  = (i == q.size() - 1);
                    r.value = '0;
                    r.ovf   = 1'b0;
                    due_results.push_back(r);
                end
            end else begin
                decode_byte(coded);
            end
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (want !== got) begin
                $display("t=%0t: %s mismatch, expected %0h, got %0h",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $display("t=%0t: result with nothing owed, kind %0b byte %0h value %0h",
                         $time, got.kind, got.coded, got.value);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("result_kind", 64'(want.kind), 64'(got.kind));
            compare_field("out_byte", 64'(want.coded), 64'(got.coded));
            compare_field("last_byte", 64'(want.last), 64'(got.last));
            compare_field("decoded_value", want.value, got.value);
            compare_field("overflow", 64'(want.ovf), 64'(got.ovf));
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic                      i_command;
    logic signed [VALUE_W-1:0] i_plain_value;
    logic [BYTE_W-1:0]         i_coded_byte;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_result_kind;
    logic [BYTE_W-1:0]         o_out_byte;
    logic                      o_last_byte;
    logic signed [VALUE_W-1:0] o_decoded_value;
    logic                      o_overflow;

    zz_varint_tracker tracker;
    int               items_sent;
    bit               tx_no_idle;   // sender offers back to back
    bit               rx_no_idle;   // receiver always ready
    bit               rx_hold_req;  // receiver to hold off once, for a long stretch

    zigzag_varint_codec dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_plain_value   (i_plain_value),
        .i_coded_byte    (i_coded_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_kind   (o_result_kind),
        .o_out_byte      (o_out_byte),
        .o_last_byte     (o_last_byte),
        .o_decoded_value (o_decoded_value),
        .o_overflow      (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Draw a value: full width, a sign-extended short one (so every coded
    // length turns up), or one of the extremes.
    function automatic logic [VALUE_W-1:0] draw_value();
        logic [VALUE_W-1:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return raw;
            1:       return ($urandom_range(0, 1) == 1) ? MAX_POS : MIN_NEG;
            default: return $signed(raw) >>> $urandom_range(1, VALUE_W - 1);
        endcase
    endfunction

    // Offer one item and hold it until taken. Keep valid high when the next
    // item follows at once, so valid is only ever written once per edge.
    task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] plain,
                             input logic [BYTE_W-1:0] coded);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_plain_value <= plain;
        i_coded_byte  <= coded;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_item(cmd, plain, coded);
        items_sent++;
    endtask

    // The unused field of each item carries random data
    task automatic send_encode(input logic [VALUE_W-1:0] v);
        send_item(CMD_ENCODE, v, BYTE_W'($urandom));
    endtask

    task automatic send_decode(input logic [BYTE_W-1:0] b);
        send_item(CMD_DECODE, {$urandom, $urandom}, b);
    endtask

    task automatic send_continuation_run(input int count);
        repeat (count) send_decode(8'h80 | BYTE_W'($urandom_range(0, 127)));
    endtask

    // Drop valid and pause until everything owed has come back; advance at
    // least one edge so valid is written once per time step
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // One random sequence: most often well-formed coded values with random
    // content, the rest plain encodes, overflowing runs and loose bytes.
    task automatic random_sequence();
        t_code_q q;
        int      pick;
        int      cut;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_encode(draw_value());
        end else if (pick < 80) begin
            tracker.code_value(draw_value(), q);
            // now and then slip an encode into the middle of the decode
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, q.size() - 1) : -1;
            foreach (q[i]) begin
                if (i == cut) send_encode(draw_value());
                send_decode(q[i]);
            end
        end else if (pick < 88) begin
            send_continuation_run(MAX_CODED_BYTES);
        end else if (pick < 93) begin
            send_continuation_run(MAX_CODED_BYTES - 1);
            send_decode(BYTE_W'($urandom_range(2, 255)));
        end else begin
            repeat ($urandom_range(1, 4))
                send_item(1'($urandom), {$urandom, $urandom}, BYTE_W'($urandom));
        end
    endtask

    task automatic run_random(input int stop_at);
        while (items_sent < stop_at) random_sequence();
    endtask

    // Stimulus
    initial begin
        tracker       = new();
        items_sent    = 0;
        tx_no_idle    = 1'b0;
        rx_no_idle    = 1'b0;
        rx_hold_req   = 1'b0;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_command     <= CMD_ENCODE;
        i_plain_value <= '0;
        i_coded_byte  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the encoder: shortest codes, sign edges, full length
        send_encode('0);
        send_encode(64'sd1);
        send_encode(-64'sd1);
        send_encode(64'sd63);
        send_encode(-64'sd64);
        send_encode(MAX_POS);
        send_encode(MIN_NEG);

        // Single-byte decodes and one two-byte decode
        send_decode(8'h00);
        send_decode(8'h01);
        send_decode(8'h7f);
        send_decode(8'hff);
        send_decode(8'h7f);

        // Encode in the middle of a decode: the partial decode must survive
        send_decode(8'h85);
        send_encode(-64'sd5);
        send_decode(8'h03);

        // Tenth byte too large for the last position
        repeat (MAX_CODED_BYTES - 1) send_decode(8'hff);
        send_decode(8'h02);
        wait_for_results();

        // Random part, opened by a run of too many continuation bytes
        send_continuation_run(MAX_CODED_BYTES);
        run_random(CALM_FROM);
        wait_for_results();

        // Stretch with no idling on either side
        tx_no_idle = 1'b1;
        rx_no_idle = 1'b1;
        run_random(HOLD_FROM);
        wait_for_results();
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;

        // Long hold-off at the receiver while items keep coming back to back
        rx_hold_req = 1'b1;
        tx_no_idle  = 1'b1;
        run_random(items_sent + HOLD_RUN_ITEMS);
        tx_no_idle  = 1'b0;
        run_random(TOTAL_ITEMS);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("tb_zigzag_varint_codec: PASS");
        end else begin
            $display("tb_zigzag_varint_codec: FAIL");
        end
        $finish;
    end

    // Receiver: idle at random per result, and hold off once on request
    initial begin
        int      gap;
        t_result got;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_req) begin
                gap         = RX_HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got.kind  = o_result_kind;
            got.coded = o_out_byte;
            got.last  = o_last_byte;
            got.value = o_decoded_value;
            got.ovf   = o_overflow;
            tracker.check_result(got);
        end
    end

    // Watchdog: advance a count on every edge at which nothing moves
    initial begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                stalled = 0;
            end else begin
                stalled++;
            end
        end
        $display("t=%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tb_zigzag_varint_codec: FAIL");
        $finish;
    end

endmodule
